// ===== hdl/cvw_pkg.sv =====
// Shared constants, types and register indices of the KxK valid-window convolution core.
`default_nettype none
package cvw_pkg;
   localparam int KERNEL_SIZE = 7;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int KSQ         = KERNEL_SIZE * KERNEL_SIZE;
   localparam int TAPS        = KERNEL_SIZE - 1;
   localparam int HALF        = KERNEL_SIZE / 2;

   localparam int PIX_W      = 16;
   localparam int COEF_IDX_W = 6;
   localparam int COORD_W    = 10;
   localparam int DIM_W      = 11;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int CMP_W      = (DIM_W > ADDR_W + 1) ? DIM_W : ADDR_W + 1;
   localparam int LINE_W     = PIX_W * TAPS;
   localparam int PROD_W     = 2 * PIX_W;
   localparam int ROW_W      = PROD_W + $clog2(KERNEL_SIZE);
   localparam int SUM_W      = PROD_W + $clog2(KSQ);

   localparam int REQ_DATA_W = ((2 * PIX_W + COEF_IDX_W + 7) / 8) * 8;
   localparam int RSP_FLD_W  = PIX_W + 2 * COORD_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_COEF  = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic                  cmd;
      logic [PIX_W-1:0]      px;
      logic [ADDR_W-1:0]     col;
      logic [COEF_IDX_W-1:0] coef_index;
      logic [PIX_W-1:0]      coef_value;
      logic                  emit;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic                  last;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } meta_type;

   typedef struct packed {
      logic             shift;
      logic             mac_en;
      logic             wt_wr;
      logic [PIX_W-1:0] wt_value;
   } cell_ctl_type;
endpackage
`default_nettype wire

// ===== hdl/cvw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cvw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== hdl/cvw_cell.sv =====
// One window cell: a pixel register in the shift row, its weight and a registered product.
`default_nettype none
module cvw_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cvw_pkg::cell_ctl_type        ctl,
   input  wire logic                         wt_sel,
   input  wire logic [cvw_pkg::PIX_W-1:0]    pix_from_right,
   output logic      [cvw_pkg::PIX_W-1:0]    pix_to_left,
   output logic      [cvw_pkg::PROD_W-1:0]   prod
);
   logic [cvw_pkg::PIX_W-1:0]  pixel_ff;
   logic [cvw_pkg::PIX_W-1:0]  weight_ff;
   logic [cvw_pkg::PROD_W-1:0] prod_ff;
   logic [cvw_pkg::PROD_W-1:0] prod_in;

   assign prod_in = cvw_pkg::PROD_W'(pixel_ff) * cvw_pkg::PROD_W'(weight_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else if (ctl.wt_wr && wt_sel) begin
         weight_ff <= ctl.wt_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         pixel_ff <= pix_from_right;
      end
      if (ctl.mac_en) begin
         prod_ff <= prod_in;
      end
   end

   assign pix_to_left = pixel_ff;
   assign prod        = prod_ff;
endmodule
`default_nettype wire

// ===== hdl/cvw_sum.sv =====
// Two-stage registered adder tree with round-half-up and saturation to 16 bits.
`default_nettype none
module cvw_sum (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [cvw_pkg::PROD_W-1:0] prods [cvw_pkg::KSQ],
   output logic      [cvw_pkg::PIX_W-1:0]  filtered
);
   localparam int RES_W = cvw_pkg::SUM_W + 1 - cvw_pkg::PIX_W;

   logic [cvw_pkg::ROW_W-1:0] rowsum_ff [cvw_pkg::KERNEL_SIZE];
   logic [cvw_pkg::ROW_W-1:0] rowsum_in [cvw_pkg::KERNEL_SIZE];
   logic [cvw_pkg::PIX_W-1:0] filtered_ff;
   logic [cvw_pkg::PIX_W-1:0] filtered_in;
   logic [cvw_pkg::SUM_W:0]   total;
   logic [RES_W-1:0]          res;

   always_comb begin
      for (int r = 0; r < cvw_pkg::KERNEL_SIZE; r++) begin
         rowsum_in[r] = '0;
         for (int c = 0; c < cvw_pkg::KERNEL_SIZE; c++) begin
            rowsum_in[r] = rowsum_in[r]
                         + cvw_pkg::ROW_W'(prods[r * cvw_pkg::KERNEL_SIZE + c]);
         end
      end
   end

   always_comb begin
      total = (cvw_pkg::SUM_W + 1)'(1) << (cvw_pkg::PIX_W - 1);
      for (int r = 0; r < cvw_pkg::KERNEL_SIZE; r++) begin
         total = total + (cvw_pkg::SUM_W + 1)'(rowsum_ff[r]);
      end
      res = total[cvw_pkg::SUM_W:cvw_pkg::PIX_W];
      if (res > RES_W'({cvw_pkg::PIX_W{1'b1}})) begin
         filtered_in = '1;
      end else begin
         filtered_in = res[cvw_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rowsum_ff   <= rowsum_in;
         filtered_ff <= filtered_in;
      end
   end

   assign filtered = filtered_ff;
endmodule
`default_nettype wire

// ===== hdl/conv2d_valid_window_core.sv =====
// Top level of the KxK valid-window convolution core with line store and cell array.
// A pixel passes the first stage, cell pixel, product, row sums and output registers.
// Throughput: one item per cycle; the whole pipeline advances only while the output register
// is empty or being drained, so a stalled output holds every stage in place.
// Reset clears counters, valid bits, weights and restores width 640 and height 480.
// The line store needs no clearing pass and is ready right after reset.
`default_nettype none
module conv2d_valid_window_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0: pixel, coef_index, coef_value, zero padding.
   input  wire logic [cvw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Fields from bit 0: command.
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // Fields from bit 0: filtered, out_x, out_y, zero padding.
   output logic      [cvw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_we,
   input  wire logic [cvw_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [cvw_pkg::DIM_W-1:0]          csr_wdata
);
   localparam int K  = cvw_pkg::KERNEL_SIZE;
   localparam int PW = cvw_pkg::PIX_W;
   localparam int CW = cvw_pkg::CMP_W;
   localparam int AW = cvw_pkg::ADDR_W;

   logic [cvw_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [AW-1:0]               col_ff;
   logic [cvw_pkg::COORD_W-1:0] row_ff;
   logic [CW-1:0]               w_eff, h_eff;
   logic [CW-1:0]               col_a, row_a, col_n, row_n;
   logic                        emit_c, last_c;

   cvw_pkg::item_type s1_ff, s1_in, s2_ff;
   cvw_pkg::meta_type s3_ff, s3_in, s4_ff;
   logic                        rsp_valid_ff;
   logic [cvw_pkg::COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                        rsp_last_ff;

   logic                        pipe_en, accept, pix_accept, shift;
   logic                        bypass_ff, bypass_in;
   logic [cvw_pkg::LINE_W-1:0]  bypass_data_ff, ram_rd, col_rd, line_wr;
   logic [PW-1:0]               column [K];
   logic [PW-1:0]               win_pix [K][K];
   logic [cvw_pkg::PROD_W-1:0]  prods [cvw_pkg::KSQ];
   logic [PW-1:0]               filtered;
   cvw_pkg::cell_ctl_type       cell_ctl;

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;
   assign accept     = pipe_en && req_tvalid;
   assign pix_accept = accept && (req_tuser == cvw_pkg::CMD_PIXEL);
   assign shift      = pipe_en && s1_ff.valid && (s1_ff.cmd == cvw_pkg::CMD_PIXEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cvw_pkg::WIDTH_RESET;
         height_ff <= cvw_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            cvw_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            cvw_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (CW'(width_ff) > CW'(cvw_pkg::MAX_WIDTH)) begin
         w_eff = CW'(cvw_pkg::MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = CW'(1);
      end else if (CW'(height_ff) > CW'(cvw_pkg::MAX_HEIGHT)) begin
         h_eff = CW'(cvw_pkg::MAX_HEIGHT);
      end else begin
         h_eff = CW'(height_ff);
      end
   end

   always_comb begin
      col_a = CW'(col_ff);
      row_a = CW'(row_ff);
      if (col_a >= w_eff) begin
         col_a = '0;
         row_a = row_a + CW'(1);
      end
      if (row_a >= h_eff) begin
         row_a = '0;
      end
      emit_c = (col_a >= CW'(cvw_pkg::TAPS)) && (row_a >= CW'(cvw_pkg::TAPS));
      last_c = (col_a + CW'(1) >= w_eff) && (row_a + CW'(1) >= h_eff);
      col_n  = col_a + CW'(1);
      row_n  = row_a;
      if (col_n >= w_eff) begin
         col_n = '0;
         row_n = row_a + CW'(1);
         if (row_n >= h_eff) begin
            row_n = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_accept) begin
         col_ff <= col_n[AW-1:0];
         row_ff <= row_n[cvw_pkg::COORD_W-1:0];
      end
   end

   always_comb begin
      s1_in.valid      = req_tvalid;
      s1_in.cmd        = req_tuser;
      s1_in.px         = req_tdata[PW-1:0];
      s1_in.col        = col_a[AW-1:0];
      s1_in.coef_index = req_tdata[PW +: cvw_pkg::COEF_IDX_W];
      s1_in.coef_value = req_tdata[PW + cvw_pkg::COEF_IDX_W +: PW];
      s1_in.emit       = (req_tuser == cvw_pkg::CMD_PIXEL) && emit_c;
      s1_in.x          = cvw_pkg::COORD_W'(col_a - CW'(cvw_pkg::TAPS - cvw_pkg::HALF));
      s1_in.y          = cvw_pkg::COORD_W'(row_a - CW'(cvw_pkg::TAPS - cvw_pkg::HALF));
      s1_in.last       = (req_tuser == cvw_pkg::CMD_PIXEL) && last_c;
   end

   assign s3_in.valid = s2_ff.valid && (s2_ff.cmd == cvw_pkg::CMD_PIXEL) && s2_ff.emit;
   assign s3_in.x     = s2_ff.x;
   assign s3_in.y     = s2_ff.y;
   assign s3_in.last  = s2_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         s4_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bypass_ff    <= 1'b0;
      end else if (pipe_en) begin
         s1_ff        <= s1_in;
         s2_ff        <= s1_ff;
         s3_ff        <= s3_in;
         s4_ff        <= s4_ff.valid ? s3_ff : s3_ff;
         rsp_valid_ff <= s4_ff.valid;
         bypass_ff    <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_x_ff    <= s4_ff.x;
         rsp_y_ff    <= s4_ff.y;
         rsp_last_ff <= s4_ff.last;
      end
      if (bypass_in) begin
         bypass_data_ff <= line_wr;
      end
   end

   // A pixel in the same column as the one being written back reads stale RAM data.
   assign bypass_in = pix_accept && shift && (s1_ff.col == col_a[AW-1:0]);
   assign col_rd    = bypass_ff ? bypass_data_ff : ram_rd;

   always_comb begin
      for (int r = 0; r < cvw_pkg::TAPS; r++) begin
         column[r] = col_rd[r * PW +: PW];
      end
      column[cvw_pkg::TAPS] = s1_ff.px;
      for (int r = 0; r < cvw_pkg::TAPS; r++) begin
         line_wr[r * PW +: PW] = column[r + 1];
      end
   end

   cvw_ram #(
      .WIDTH (cvw_pkg::LINE_W),
      .DEPTH (cvw_pkg::MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (s1_ff.col),
      .wr_data (line_wr),
      .rd_en   (pix_accept),
      .rd_addr (col_a[AW-1:0]),
      .rd_data (ram_rd)
   );

   assign cell_ctl.shift    = shift;
   assign cell_ctl.mac_en   = pipe_en;
   assign cell_ctl.wt_wr    = pipe_en && s2_ff.valid && (s2_ff.cmd == cvw_pkg::CMD_COEF);
   assign cell_ctl.wt_value = s2_ff.coef_value;

   for (genvar r = 0; r < K; r++) begin : g_row
      for (genvar c = 0; c < K; c++) begin : g_col
         logic [PW-1:0] pix_from_right;
         logic          wt_sel;

         if (c == K - 1) begin : g_edge
            assign pix_from_right = column[r];
         end else begin : g_inner
            assign pix_from_right = win_pix[r][c + 1];
         end

         assign wt_sel = (int'(s2_ff.coef_index) == r * K + c);

         cvw_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (cell_ctl),
            .wt_sel         (wt_sel),
            .pix_from_right (pix_from_right),
            .pix_to_left    (win_pix[r][c]),
            .prod           (prods[r * K + c])
         );
      end
   end

   cvw_sum u_sum (
      .clock    (clock),
      .en       (pipe_en),
      .prods    (prods),
      .filtered (filtered)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(cvw_pkg::RSP_DATA_W - cvw_pkg::RSP_FLD_W){1'b0}},
                        rsp_y_ff, rsp_x_ff, filtered};

   a_bypass_needs_pixel: assert property (@(posedge clock) disable iff (reset)
      bypass_ff |-> (s1_ff.valid && (s1_ff.cmd == cvw_pkg::CMD_PIXEL)))
      else $error("line store bypass armed without a pixel in the first stage");

   a_coef_no_emit: assert property (@(posedge clock) disable iff (reset)
      (s2_ff.valid && (s2_ff.cmd == cvw_pkg::CMD_COEF)) |-> !s2_ff.emit)
      else $error("coefficient transfer marked as producing a result");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_ff.valid))
      else $error("result appeared without a valid item in the last stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (!pipe_en && s1_ff.valid) |=> (s1_ff.valid && $stable(s1_ff.col)))
      else $error("first stage changed while the pipeline was stalled");
endmodule
`default_nettype wire

// ===== sim/conv2d_valid_window_checker.sv =====
// Checker for the convolution core: predicts each window result and compares the result stream.
module conv2d_valid_window_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   // Fields from bit 0: pixel, coef_index, coef_value, zero padding.
   input  wire logic [cvw_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: command.
   input  wire logic                           req_tuser,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // Fields from bit 0: filtered, out_x, out_y, zero padding.
   input  wire logic [cvw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           rsp_tlast,
   input  wire logic                           csr_we,
   input  wire logic [cvw_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [cvw_pkg::DIM_W-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LINES = 100;

   typedef struct packed {
      logic [cvw_pkg::PIX_W-1:0]   filtered;
      logic [cvw_pkg::COORD_W-1:0] x;
      logic [cvw_pkg::COORD_W-1:0] y;
      logic                        last;
   } window_sum_type;

   window_sum_type            window_sums_q[$];
   logic [cvw_pkg::PIX_W-1:0] line_mem [cvw_pkg::TAPS][cvw_pkg::MAX_WIDTH];
   logic [cvw_pkg::PIX_W-1:0] win [cvw_pkg::KERNEL_SIZE][cvw_pkg::KERNEL_SIZE];
   logic [cvw_pkg::PIX_W-1:0] coef [cvw_pkg::KSQ];
   int unsigned               col_pos;
   int unsigned               row_pos;
   logic [cvw_pkg::DIM_W-1:0] width_reg;
   logic [cvw_pkg::DIM_W-1:0] height_reg;

   function automatic int unsigned fit_size(input logic [cvw_pkg::DIM_W-1:0] v,
                                            input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LINES) $display("%0t: mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic absorb_item(input logic cmd, input logic [cvw_pkg::REQ_DATA_W-1:0] data);
      logic [cvw_pkg::PIX_W-1:0]      column [cvw_pkg::KERNEL_SIZE];
      logic [63:0]                    acc;
      logic [cvw_pkg::COEF_IDX_W-1:0] idx;
      int unsigned                    w;
      int unsigned                    h;
      int unsigned                    col;
      int unsigned                    row;
      int                             r;
      int                             c;
      window_sum_type                 res;
      idx = data[cvw_pkg::PIX_W +: cvw_pkg::COEF_IDX_W];
      if (cmd == cvw_pkg::CMD_COEF) begin
         if (idx < cvw_pkg::KSQ)
            coef[idx] = data[cvw_pkg::PIX_W+cvw_pkg::COEF_IDX_W +: cvw_pkg::PIX_W];
         return;
      end
      w = fit_size(width_reg, cvw_pkg::MAX_WIDTH);
      h = fit_size(height_reg, cvw_pkg::MAX_HEIGHT);
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      col = col_pos;
      row = row_pos;

      for (r = 0; r < cvw_pkg::TAPS; r++) column[r] = line_mem[r][col];
      column[cvw_pkg::TAPS] = data[cvw_pkg::PIX_W-1:0];
      for (r = 0; r < cvw_pkg::TAPS; r++) line_mem[r][col] = column[r+1];
      for (r = 0; r < cvw_pkg::KERNEL_SIZE; r++) begin
         for (c = 0; c < cvw_pkg::KERNEL_SIZE - 1; c++) win[r][c] = win[r][c+1];
         win[r][cvw_pkg::KERNEL_SIZE-1] = column[r];
      end

      if (col >= cvw_pkg::TAPS && row >= cvw_pkg::TAPS) begin
         acc = '0;
         for (r = 0; r < cvw_pkg::KERNEL_SIZE; r++)
            for (c = 0; c < cvw_pkg::KERNEL_SIZE; c++)
               acc += 64'(win[r][c]) * 64'(coef[r*cvw_pkg::KERNEL_SIZE+c]);
         acc = (acc + 64'h8000) >> 16;
         res.filtered = (acc > 64'hFFFF) ? 16'hFFFF : acc[cvw_pkg::PIX_W-1:0];
         res.x        = cvw_pkg::COORD_W'(col - cvw_pkg::TAPS + cvw_pkg::HALF);
         res.y        = cvw_pkg::COORD_W'(row - cvw_pkg::TAPS + cvw_pkg::HALF);
         res.last     = (col + 1 >= w) && (row + 1 >= h);
         window_sums_q = {window_sums_q, res};
      end

      col_pos = col + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic check_result(input logic [cvw_pkg::RSP_DATA_W-1:0] data, input logic last);
      window_sum_type got;
      window_sum_type want;
      got.filtered = data[cvw_pkg::PIX_W-1:0];
      got.x        = data[cvw_pkg::PIX_W +: cvw_pkg::COORD_W];
      got.y        = data[cvw_pkg::PIX_W+cvw_pkg::COORD_W +: cvw_pkg::COORD_W];
      got.last     = last;
      if (window_sums_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result filtered %h at (%0d,%0d) last %b",
                                   got.filtered, got.x, got.y, got.last));
         return;
      end
      want = window_sums_q.pop_front();
      if (got.filtered !== want.filtered)
         report_mismatch($sformatf("filtered %h, predicted %h at (%0d,%0d)",
                                   got.filtered, want.filtered, want.x, want.y));
      if (got.x !== want.x)
         report_mismatch($sformatf("out_x %0d, predicted %0d", got.x, want.x));
      if (got.y !== want.y)
         report_mismatch($sformatf("out_y %0d, predicted %0d", got.y, want.y));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %b, predicted %b at (%0d,%0d)",
                                   got.last, want.last, want.x, want.y));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cvw_pkg::KSQ; i++) coef[i] = '0;
         for (int r = 0; r < cvw_pkg::TAPS; r++)
            for (int c = 0; c < cvw_pkg::MAX_WIDTH; c++) line_mem[r][c] = '0;
         for (int r = 0; r < cvw_pkg::KERNEL_SIZE; r++)
            for (int c = 0; c < cvw_pkg::KERNEL_SIZE; c++) win[r][c] = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = cvw_pkg::WIDTH_RESET;
         height_reg = cvw_pkg::HEIGHT_RESET;
         window_sums_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) absorb_item(req_tuser, req_tdata);
         if (csr_we) begin
            case (csr_addr)
               cvw_pkg::CSR_IMAGE_WIDTH:  width_reg = csr_wdata;
               cvw_pkg::CSR_IMAGE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      pending <= window_sums_q.size();
   end
endmodule

// ===== sim/tb_conv2d_valid_window_core.sv =====
// Testbench top: drives frames, weight updates and frame geometry into the convolution core.
module tb_conv2d_valid_window_core ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 12;
   localparam int QUIET_LIMIT    = 2000;
   localparam int RANDOM_PIXELS  = 300;
   localparam int OPENING_PIXELS = 40;

   typedef enum int {PIX_FULL, PIX_EXTREME, PIX_DIM} pixel_mix_type;
   typedef enum int {WT_RANDOM, WT_MAX, WT_ZERO, WT_SINGLE, WT_LOW} weight_mix_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [cvw_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = cvw_pkg::CMD_PIXEL;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [cvw_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_we = 1'b0;
   logic [cvw_pkg::CSR_ADDR_W-1:0] csr_addr = cvw_pkg::CSR_IMAGE_WIDTH;
   logic [cvw_pkg::DIM_W-1:0]      csr_wdata = '0;
   logic                           steady = 1'b0;
   int                             fail_count;
   int                             pending;
   int unsigned                    frame_pixels = 0;
   int unsigned                    quiet_cycles = 0;

   conv2d_valid_window_core u_dut (.*);

   conv2d_valid_window_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) rsp_tready <= steady || ($urandom_range(99) >= 32);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic cmd, input logic [cvw_pkg::PIX_W-1:0] px,
                            input logic [cvw_pkg::COEF_IDX_W-1:0] idx,
                            input logic [cvw_pkg::PIX_W-1:0] value);
      logic [cvw_pkg::REQ_DATA_W-1:0] data;
      data = '0;
      data[cvw_pkg::PIX_W-1:0] = px;
      data[cvw_pkg::PIX_W +: cvw_pkg::COEF_IDX_W] = idx;
      data[cvw_pkg::PIX_W+cvw_pkg::COEF_IDX_W +: cvw_pkg::PIX_W] = value;
      while (!steady && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_coef();
      send_item(cvw_pkg::CMD_COEF, cvw_pkg::PIX_W'($urandom),
                cvw_pkg::COEF_IDX_W'($urandom), cvw_pkg::PIX_W'($urandom));
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame(input logic [cvw_pkg::DIM_W-1:0] w,
                            input logic [cvw_pkg::DIM_W-1:0] h);
      int unsigned fw;
      int unsigned fh;
      fw = (w == 0) ? 1 : (w > cvw_pkg::MAX_WIDTH) ? cvw_pkg::MAX_WIDTH : 32'(w);
      fh = (h == 0) ? 1 : (h > cvw_pkg::MAX_HEIGHT) ? cvw_pkg::MAX_HEIGHT : 32'(h);
      frame_pixels = fw * fh;
      settle();
      csr_we <= 1'b1;
      csr_addr <= cvw_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr <= cvw_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_weights(input weight_mix_type mix);
      int unsigned               hot;
      int unsigned               i;
      logic [cvw_pkg::PIX_W-1:0] value;
      hot = $urandom_range(cvw_pkg::KSQ - 1);
      for (i = 0; i < cvw_pkg::KSQ; i++) begin
         case (mix)
            WT_RANDOM: value = cvw_pkg::PIX_W'($urandom);
            WT_MAX:    value = 16'hFFFF;
            WT_ZERO:   value = 16'h0000;
            WT_SINGLE: value = (i == hot) ? cvw_pkg::PIX_W'($urandom) : 16'h0000;
            default:   value = cvw_pkg::PIX_W'($urandom_range(2047));
         endcase
         send_item(cvw_pkg::CMD_COEF, cvw_pkg::PIX_W'($urandom),
                   cvw_pkg::COEF_IDX_W'(i), value);
      end
   endtask

   task automatic send_pixels(input int unsigned total, input pixel_mix_type mix,
                              input bit hold);
      int unsigned               hold_at;
      int unsigned               n;
      logic [cvw_pkg::PIX_W-1:0] px;
      hold_at = hold ? $urandom_range(total - 1) : total;
      for (n = 0; n < total; n++) begin
         if (n == hold_at) wait_results();
         if ($urandom_range(39) == 0) send_random_coef();
         case (mix)
            PIX_FULL:    px = cvw_pkg::PIX_W'($urandom);
            PIX_EXTREME: px = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default:     px = cvw_pkg::PIX_W'($urandom_range(255));
         endcase
         send_item(cvw_pkg::CMD_PIXEL, px, cvw_pkg::COEF_IDX_W'($urandom),
                   cvw_pkg::PIX_W'($urandom));
      end
   endtask

   initial begin
      int unsigned               shaped;
      int unsigned               frames;
      int unsigned               pick;
      int unsigned               phase;
      logic [cvw_pkg::DIM_W-1:0] w;
      logic [cvw_pkg::DIM_W-1:0] h;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Weight writes at the table corners and centre; the last two indexes are out of range.
      send_item(cvw_pkg::CMD_COEF, 16'hFFFF, 6'd0, 16'hFFFF);
      send_item(cvw_pkg::CMD_COEF, 16'h0000, cvw_pkg::COEF_IDX_W'(cvw_pkg::KSQ - 1), 16'h0001);
      send_item(cvw_pkg::CMD_COEF, 16'hFFFF, cvw_pkg::COEF_IDX_W'(cvw_pkg::KSQ / 2), 16'h8000);
      send_item(cvw_pkg::CMD_COEF, 16'h0000, cvw_pkg::COEF_IDX_W'(cvw_pkg::KSQ), 16'hFFFF);
      send_item(cvw_pkg::CMD_COEF, 16'hFFFF, 6'h3F, 16'hFFFF);

      // A partial row at the reset geometry; the one-row frame after it restarts the count.
      send_pixels(OPENING_PIXELS, PIX_FULL, 1'b1);
      set_frame(11'd7, 11'd0);
      send_pixels(frame_pixels, PIX_EXTREME, 1'b0);
      set_frame(11'd0, 11'd3);
      send_pixels(frame_pixels, PIX_EXTREME, 1'b0);
      steady <= 1'b1;
      set_frame(11'd12, 11'd8);
      send_pixels(frame_pixels, PIX_FULL, 1'b0);
      steady <= 1'b0;

      shaped = 0;
      phase = 0;
      while (shaped < RANDOM_PIXELS) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            w = cvw_pkg::DIM_W'($urandom_range(6));
            h = cvw_pkg::DIM_W'($urandom_range(12));
         end else if (pick == 1) begin
            w = cvw_pkg::DIM_W'($urandom_range(7, 14));
            h = cvw_pkg::DIM_W'($urandom_range(6));
         end else begin
            w = cvw_pkg::DIM_W'($urandom_range(7, 14));
            h = cvw_pkg::DIM_W'($urandom_range(7, 10));
         end
         set_frame(w, h);
         if ($urandom_range(2) != 0)
            load_weights(weight_mix_type'($urandom_range(4)));
         else
            repeat ($urandom_range(1, 4)) send_random_coef();
         frames = $urandom_range(1, 2);
         send_pixels(frames * frame_pixels, pixel_mix_type'($urandom_range(2)),
                     phase == 0 || $urandom_range(3) == 0);
         shaped += frames * frame_pixels;
         phase++;
      end

      wait_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
